[design/sorted_edge_entry_validator_defines.svh]
// assertion macros for sorted_edge_entry_validator.sv
`ifndef SORTED_EDGE_ENTRY_VALIDATOR_DEFINES_SVH
`define SORTED_EDGE_ENTRY_VALIDATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define SEV_ASSERT_ON(lbl, ck, rs, prop) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error("assertion failed");
`define SEV_ASSERT(lbl, prop) `SEV_ASSERT_ON(lbl, clk, rst, prop)
`else
`define SEV_ASSERT_ON(lbl, ck, rs, prop)
`define SEV_ASSERT(lbl, prop)
`endif
`endif

[design/sev_pkg.sv]
package sev_pkg;

  localparam int MAX_EDGES_DEFAULT = 4096;
  localparam int EPOCH_W = 8;

  localparam logic CMD_BEGIN = 1'b0;
  localparam logic CMD_CHECK = 1'b1;

  localparam logic CFG_FIRST_EDGE = 1'b0;
  localparam logic CFG_EDGE_TOTAL = 1'b1;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_CFG_BAD  = 3'd1;
  localparam logic [2:0] ST_CRC_BAD  = 3'd2;
  localparam logic [2:0] ST_RANGE    = 3'd3;
  localparam logic [2:0] ST_ORDER    = 3'd4;
  localparam logic [2:0] ST_DUP      = 3'd5;
  localparam logic [2:0] ST_TOO_MANY = 3'd6;
  localparam logic [2:0] ST_FAILED   = 3'd7;

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;

  // reflected crc-32 over node then address, both little-endian
  function automatic logic [31:0] entry_crc(input logic [31:0] node, input logic [31:0] addr);
    logic [63:0] data;
    logic [31:0] crc;
    logic        fb;
    data = {addr, node};
    crc  = '1;
    for (int i = 0; i < 64; i++) begin
      fb  = crc[0] ^ data[i];
      crc = {1'b0, crc[31:1]};
      if (fb) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return ~crc;
  endfunction

endpackage

[design/sev_seen_map.sv]
module sev_seen_map #(
  parameter int MAX_EDGES = sev_pkg::MAX_EDGES_DEFAULT,
  localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        rd_en,
  input  logic [ADDR_W-1:0]           rd_addr,
  output logic [sev_pkg::EPOCH_W-1:0] rd_tag,
  input  logic                        wr_en,
  input  logic [ADDR_W-1:0]           wr_addr,
  input  logic [sev_pkg::EPOCH_W-1:0] wr_tag,
  input  logic                        clear_start,
  output logic                        clear_busy
);

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_EDGES - 1);

  logic [sev_pkg::EPOCH_W-1:0] mem [MAX_EDGES];
  logic [ADDR_W-1:0]           clear_addr;
  logic                        mem_we;
  logic [ADDR_W-1:0]           mem_wa;
  logic [sev_pkg::EPOCH_W-1:0] mem_wd;

  // sweep writes tag zero, which never matches a live epoch
  always_ff @(posedge clk) begin
    if (rst || clear_start) begin
      clear_busy <= 1'b1;
      clear_addr <= '0;
    end else if (clear_busy) begin
      if (clear_addr == LAST_ADDR) begin
        clear_busy <= 1'b0;
      end
      clear_addr <= clear_addr + 1'b1;
    end
  end

  always_comb begin
    mem_we = clear_busy || wr_en;
    mem_wa = clear_busy ? clear_addr : wr_addr;
    mem_wd = clear_busy ? '0 : wr_tag;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_tag <= mem[rd_addr];
    end
  end

endmodule

[design/sorted_edge_entry_validator.sv]
// Checks one pass of index entries (configuration, entry count, crc-32, address range, strict
// (node, edge) order, repeated edge) and returns one status word per input word. Words are
// taken one per cycle with no bubbles unless a sweep, a pass-tag wrap or a stalled output
// stops input; each result is held in an output register so one more word can be taken
// while a result waits. Repeated edges are tracked in a MAX_EDGES-entry memory of 8-bit pass
// tags, one read at input and one write per cycle, with forwarding of the last write. That
// memory is swept after reset and after every 255th begin-pass word; input ready stays low
// during the sweep. Configuration writes take effect at once and are meant for an idle block.
`include "sorted_edge_entry_validator_defines.svh"

module sorted_edge_entry_validator #(
  parameter int MAX_EDGES = sev_pkg::MAX_EDGES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        command,
  input  logic [31:0] node_id,
  input  logic [31:0] edge_address,
  input  logic [31:0] stored_check,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic        pass_done,
  output logic [12:0] entries_checked
);

  localparam int ADDR_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [31:0] MAX_EDGES_W = 32'(MAX_EDGES);
  localparam int EW = sev_pkg::EPOCH_W;

  logic [31:0]       first_edge_address;
  logic [12:0]       edge_total;

  logic              s1_valid;
  logic              s1_command;
  logic [31:0]       s1_node;
  logic [31:0]       s1_edge;
  logic              s1_crc_ok;
  logic              s1_in_range;
  logic [ADDR_W-1:0] s1_addr;
  logic [EW-1:0]     s1_tag;

  logic [31:0]       previous_node;
  logic [31:0]       previous_edge;
  logic              have_previous;
  logic [12:0]       entry_counter;
  logic              pass_failed;
  logic [EW-1:0]     epoch;
  logic              fwd_valid;
  logic [ADDR_W-1:0] fwd_addr;

  logic              out_free;
  logic              s1_move;
  logic              s1_begin;
  logic              wrap_hold;
  logic              in_fire;
  logic [32:0]       in_diff;
  logic              in_range;
  logic              cfg_ok;
  logic              order_bad;
  logic              seen;
  logic [12:0]       count_inc;
  logic [2:0]        status_next;
  logic              pass_done_next;
  logic [12:0]       count_next;
  logic              fail_set;
  logic              accept_entry;
  logic              wr_en;
  logic              clear_start;
  logic              clear_busy;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      first_edge_address <= '0;
      edge_total         <= 13'd1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sev_pkg::CFG_FIRST_EDGE: first_edge_address <= cfg_data;
        sev_pkg::CFG_EDGE_TOTAL: edge_total <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // handshake
  always_comb begin
    out_free  = !out_valid || out_ready;
    s1_move   = s1_valid && out_free;
    s1_begin  = s1_command == sev_pkg::CMD_BEGIN;
    wrap_hold = s1_valid && s1_begin && (epoch == {EW{1'b1}});
    in_ready  = !clear_busy && !wrap_hold && (!s1_valid || out_free);
    in_fire   = in_valid && in_ready;
  end

  // input side work: crc, range and memory address
  always_comb begin
    in_diff  = {1'b0, edge_address} - {1'b0, first_edge_address};
    in_range = !in_diff[32] && (in_diff[31:0] < {19'b0, edge_total});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_command  <= command;
      s1_node     <= node_id;
      s1_edge     <= edge_address;
      s1_crc_ok   <= sev_pkg::entry_crc(node_id, edge_address) == stored_check;
      s1_in_range <= in_range;
      s1_addr     <= in_diff[ADDR_W-1:0];
    end
  end

  sev_seen_map #(
    .MAX_EDGES(MAX_EDGES)
  ) u_seen_map (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (in_fire),
    .rd_addr    (in_diff[ADDR_W-1:0]),
    .rd_tag     (s1_tag),
    .wr_en      (wr_en),
    .wr_addr    (s1_addr),
    .wr_tag     (epoch),
    .clear_start(clear_start),
    .clear_busy (clear_busy)
  );

  // checks
  always_comb begin
    cfg_ok = (edge_total != '0) && ({19'b0, edge_total} <= MAX_EDGES_W)
             && (({1'b0, first_edge_address} + {20'b0, edge_total}) <= 33'h0FFFFFFFF);
    order_bad = have_previous && ((s1_node < previous_node)
                || ((s1_node == previous_node) && (s1_edge <= previous_edge)));
    seen = (s1_tag == epoch) || (fwd_valid && (fwd_addr == s1_addr));
    count_inc = entry_counter + 13'd1;
  end

  always_comb begin
    status_next    = sev_pkg::ST_OK;
    pass_done_next = 1'b0;
    count_next     = entry_counter;
    fail_set       = 1'b0;
    accept_entry   = 1'b0;
    if (s1_begin) begin
      status_next = cfg_ok ? sev_pkg::ST_OK : sev_pkg::ST_CFG_BAD;
      count_next  = '0;
    end else if (pass_failed) begin
      status_next = sev_pkg::ST_FAILED;
    end else if (!cfg_ok) begin
      status_next = sev_pkg::ST_CFG_BAD;
      fail_set    = 1'b1;
    end else if (entry_counter >= edge_total) begin
      status_next = sev_pkg::ST_TOO_MANY;
      fail_set    = 1'b1;
    end else if (!s1_crc_ok) begin
      status_next = sev_pkg::ST_CRC_BAD;
      fail_set    = 1'b1;
    end else if (!s1_in_range) begin
      status_next = sev_pkg::ST_RANGE;
      fail_set    = 1'b1;
    end else if (order_bad) begin
      status_next = sev_pkg::ST_ORDER;
      fail_set    = 1'b1;
    end else if (seen) begin
      status_next = sev_pkg::ST_DUP;
      fail_set    = 1'b1;
    end else begin
      accept_entry   = 1'b1;
      count_next     = count_inc;
      pass_done_next = count_inc == edge_total;
    end
    wr_en       = s1_move && accept_entry;
    clear_start = s1_move && wrap_hold;
  end

  // pass state
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_node <= '0;
      previous_edge <= '0;
      have_previous <= 1'b0;
      entry_counter <= '0;
      pass_failed   <= 1'b0;
      epoch         <= EW'(1);
      fwd_valid     <= 1'b0;
    end else if (s1_move) begin
      entry_counter <= count_next;
      if (s1_begin) begin
        have_previous <= 1'b0;
        pass_failed   <= 1'b0;
        fwd_valid     <= 1'b0;
        epoch         <= wrap_hold ? EW'(1) : epoch + 1'b1;
      end else if (fail_set) begin
        pass_failed <= 1'b1;
      end else if (accept_entry) begin
        previous_node <= s1_node;
        previous_edge <= s1_edge;
        have_previous <= 1'b1;
        fwd_valid     <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      fwd_addr <= s1_addr;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      status          <= status_next;
      pass_done       <= pass_done_next;
      entries_checked <= count_next;
    end
  end

  `SEV_ASSERT(a_no_accept_while_clearing, clear_busy |-> !in_ready)
  `SEV_ASSERT(a_no_mark_while_clearing, wr_en |-> !clear_busy)
  `SEV_ASSERT(a_done_only_ok, out_valid && pass_done |-> status == sev_pkg::ST_OK)
  `SEV_ASSERT(a_begin_clears_pass, s1_move && s1_begin |=> entry_counter == '0 && !pass_failed)
  `SEV_ASSERT(a_failure_sticks, pass_failed && !(s1_move && s1_begin) |=> pass_failed)

endmodule
